// ----- rtl/lsg_pkg.sv -----
// lawnmower search guidance: shared constants and types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lsg_pkg;

    // default build parameters
    localparam int NUM_STRIPES_DEF = 8;
    localparam int GAIN_Q8_DEF     = 256;

    // field widths
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    // fixed-point constants, Q15.16
    localparam logic [33:0] FOV_HALF_Q    = 34'd59927;
    localparam logic [33:0] FOV_QUARTER_Q = 34'd29963;
    localparam logic [33:0] FOV_EIGHTH_Q  = 34'd14982;
    localparam logic [33:0] HEIGHT_TOL_Q  = 34'd1311;

    // register indexes
    localparam logic [IDX_W-1:0] REG_NORTH_MIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_NORTH_MAX   = 3'd1;
    localparam logic [IDX_W-1:0] REG_EAST_MIN    = 3'd2;
    localparam logic [IDX_W-1:0] REG_EAST_MAX    = 3'd3;
    localparam logic [IDX_W-1:0] REG_CRUISE      = 3'd4;
    localparam logic [IDX_W-1:0] REG_HEIGHT      = 3'd5;
    localparam logic [IDX_W-1:0] REG_TGT_NORTH   = 3'd6;
    localparam logic [IDX_W-1:0] REG_TGT_EAST    = 3'd7;

    // handshake between sequencer and divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // saturate a 34-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/lsg_if.sv -----
// request channels of the guidance block: sensor request in, command request out
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface lsg_sense_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] heading;
    logic signed [31:0] north_pos;
    logic signed [31:0] east_pos;
    logic signed [31:0] down_pos;
    logic signed [31:0] north_vel;
    modport source (output valid, heading, north_pos, east_pos, down_pos, north_vel,
                    input ready);
    modport sink (input valid, heading, north_pos, east_pos, down_pos, north_vel,
                  output ready);
endinterface

interface lsg_guide_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] heading_cmd;
    logic signed [31:0] pos_north_cmd;
    logic signed [31:0] pos_east_cmd;
    logic signed [31:0] pos_down_cmd;
    logic signed [31:0] vel_north_cmd;
    logic signed [31:0] vel_east_cmd;
    logic               searching;
    modport source (output valid, heading_cmd, pos_north_cmd, pos_east_cmd, pos_down_cmd,
                    vel_north_cmd, vel_east_cmd, searching, input ready);
    modport sink (input valid, heading_cmd, pos_north_cmd, pos_east_cmd, pos_down_cmd,
                  vel_north_cmd, vel_east_cmd, searching, output ready);
endinterface
`default_nettype wire

// ----- rtl/lsg_cdiv.sv -----
// divider of a signed 34-bit value by a constant, by reciprocal multiply in three steps
// depends on lsg_pkg
`timescale 1ns / 1ps
`default_nettype none
module lsg_cdiv
    import lsg_pkg::*;
#(
    parameter int DIVISOR = NUM_STRIPES_DEF - 1
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [33:0] dividend,
    output div_stat_t               stat,
    output logic signed [34:0]      quotient
);
    // reciprocal, exact for a 34-bit magnitude and a divisor up to 16
    localparam int          SHIFT = 38;
    localparam logic [38:0] RECIP =
        39'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [33:0] mag_reg, mag_next;
    logic [47:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [12:0] chunk;
    logic [46:0] part;
    logic [33:0] q_mag;

    // one 13-bit slice of the reciprocal per cycle, low slice first
    always_comb
    begin
        mag_next  = mag_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        case (cnt_reg)
            2'd0:    chunk = RECIP[12:0];
            2'd1:    chunk = RECIP[25:13];
            default: chunk = RECIP[38:26];
        endcase
        part = {13'd0, mag_reg} * {34'd0, chunk};
        if (start)
        begin
            neg_next  = dividend[33];
            mag_next  = dividend[33] ? 34'(-dividend) : dividend;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {13'd0, acc_reg[47:13]} + {1'b0, part};
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd2)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    // remaining 12 bits of the reciprocal shift
    assign q_mag     = acc_reg[45:12];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = neg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

    // done follows the last step only
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without busy");
    a_no_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(done_reg && busy_reg))
        else $error("divider busy and done together");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= 2'd2)
        else $error("divider step count out of range");

endmodule
`default_nettype wire

// ----- rtl/lawnmower_search_guidance.sv -----
// lawnmower search guidance: one command per sensor request
// steps from accept to command valid: the reciprocal-multiply stripe-spacing divide,
// the nearest-stripe walk over every stripe, then a gain multiply and a decision step;
// a new request is taken only after the last command is registered, which is held
// further while a command waits; reset clears configuration registers, state, stripe, phase and flags
// depends on lsg_pkg, lsg_if, lsg_cdiv
`timescale 1ns / 1ps
`default_nettype none
module lawnmower_search_guidance
    import lsg_pkg::*;
#(
    parameter int NUM_STRIPES = NUM_STRIPES_DEF,
    parameter int GAIN_Q8     = GAIN_Q8_DEF
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    lsg_sense_if.sink              sense,
    lsg_guide_if.source            guide,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_index,
    input  wire logic [DATA_W-1:0] wr_data
);
    localparam int SW = $clog2(NUM_STRIPES);
    localparam logic [SW-1:0] LAST = SW'(NUM_STRIPES - 1);
    localparam logic signed [16:0] GAIN_C = 17'(GAIN_Q8);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // configuration
    logic signed [31:0] nmin_reg, nmax_reg, emin_reg, emax_reg, ttn_reg, tte_reg;
    logic [30:0]        cruise_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nmin_reg   <= '0;
            nmax_reg   <= '0;
            emin_reg   <= '0;
            emax_reg   <= '0;
            cruise_reg <= '0;
            height_reg <= '0;
            ttn_reg    <= '0;
            tte_reg    <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_NORTH_MIN: nmin_reg   <= wr_data;
                REG_NORTH_MAX: nmax_reg   <= wr_data;
                REG_EAST_MIN:  emin_reg   <= wr_data;
                REG_EAST_MAX:  emax_reg   <= wr_data;
                REG_CRUISE:    cruise_reg <= wr_data[30:0];
                REG_HEIGHT:    height_reg <= wr_data[30:0];
                REG_TGT_NORTH: ttn_reg    <= wr_data;
                REG_TGT_EAST:  tte_reg    <= wr_data;
                default:       ;
            endcase
        end
    end

    // sequencer and guidance state
    logic [2:0]          state_reg, state_next;
    logic                phase_reg, phase_next;
    logic                edge_reg, edge_next;
    logic                esn_reg, esn_next;
    logic                ndn_reg, ndn_next;
    logic [SW-1:0]       stripe_reg, stripe_next;
    logic                ovalid_reg, ovalid_next;

    // datapath registers
    logic signed [31:0]  hd_reg, n_reg, e_reg, d_reg, v_reg;
    logic signed [39:0]  acc_reg;
    logic [SW-1:0]       idx_reg;
    logic [33:0]         bd_reg;
    logic [SW-1:0]       best_reg;
    logic signed [31:0]  target_reg;
    logic signed [49:0]  prod_reg;
    logic signed [31:0]  o_pn_reg, o_pe_reg, o_pd_reg, o_vn_reg, o_ve_reg, o_hd_reg;
    logic                o_srch_reg;

    logic               accept;
    logic               div_start;
    div_stat_t          div_stat;
    logic signed [34:0] delta;
    logic signed [33:0] span;

    assign accept    = sense.valid && sense.ready;
    assign div_start = accept;
    assign span      = 34'(emax_reg) - 34'(emin_reg) - $signed(FOV_HALF_Q);

    lsg_cdiv #(
        .DIVISOR (NUM_STRIPES - 1)
    ) u_cdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (span),
        .stat     (div_stat),
        .quotient (delta)
    );

    // stripe position and distance in the walk
    logic signed [31:0] pos_w;
    logic signed [33:0] dist_s;
    logic [33:0]        dist_w;
    always_comb
    begin
        if (acc_reg > 40'sh00_7FFF_FFFF)
            pos_w = 32'sh7FFF_FFFF;
        else if (acc_reg < -40'sh00_8000_0000)
            pos_w = 32'sh8000_0000;
        else
            pos_w = acc_reg[31:0];
        dist_s = 34'(pos_w) - 34'(e_reg);
        dist_w = dist_s[33] ? 34'(-dist_s) : dist_s;
    end

    // decision logic
    logic signed [33:0] n34, e34, cr34, dcmd, dd, dda;
    logic signed [33:0] emx_d, emn_d, nmx_d, nmn_d;
    logic [33:0]        emx_a, emn_a, nmx_a, nmn_a;
    logic signed [41:0] ve_raw;
    logic signed [33:0] ve_c;
    logic signed [SW+1:0] cand;
    logic               near_edge;
    logic signed [31:0] pn, pe, vn, ve;
    always_comb
    begin
        n34   = 34'(n_reg);
        e34   = 34'(e_reg);
        cr34  = $signed({3'b000, cruise_reg});
        dcmd  = -$signed({3'b000, height_reg});
        dd    = dcmd - 34'(d_reg);
        dda   = dd[33] ? -dd : dd;
        emx_d = 34'(emax_reg) - e34;
        emn_d = 34'(emin_reg) - e34;
        nmx_d = 34'(nmax_reg) - n34;
        nmn_d = 34'(nmin_reg) - n34;
        emx_a = emx_d[33] ? 34'(-emx_d) : emx_d;
        emn_a = emn_d[33] ? 34'(-emn_d) : emn_d;
        nmx_a = nmx_d[33] ? 34'(-nmx_d) : nmx_d;
        nmn_a = nmn_d[33] ? 34'(-nmn_d) : nmn_d;
        ve_raw = 42'(prod_reg >>> 8);
        near_edge = (n34 > 34'(nmax_reg) - $signed(FOV_QUARTER_Q)) ||
                    (n34 < 34'(nmin_reg) + $signed(FOV_QUARTER_Q));

        phase_next  = phase_reg;
        edge_next   = edge_reg;
        esn_next    = esn_reg;
        ndn_next    = ndn_reg;
        stripe_next = stripe_reg;
        cand        = '0;
        ve_c        = '0;
        pn = ttn_reg;
        pe = tte_reg;
        vn = '0;
        ve = '0;

        if (!phase_reg)
        begin
            // takeoff: hold target, switch when height reached
            if (dda < $signed(HEIGHT_TOL_Q))
            begin
                phase_next  = 1'b1;
                esn_next    = emx_a < emn_a;
                ndn_next    = nmx_a < nmn_a;
                stripe_next = best_reg;
            end
        end
        else
        begin
            // search: stripe tracking with edge turn-around
            if (ve_raw > 42'(cr34))
                ve_c = cr34;
            else if (ve_raw < -42'(cr34))
                ve_c = -cr34;
            else
                ve_c = ve_raw[33:0];
            if (near_edge)
            begin
                if (!edge_reg)
                begin
                    edge_next = 1'b1;
                    ndn_next  = !ndn_reg;
                    cand = esn_reg ? $signed({2'b00, stripe_reg}) - (SW+2)'(1)
                                   : $signed({2'b00, stripe_reg}) + (SW+2)'(1);
                    if (cand < 0 || cand > $signed({2'b00, LAST}))
                    begin
                        esn_next = !esn_reg;
                        cand = esn_next ? $signed({2'b00, stripe_reg}) - (SW+2)'(1)
                                        : $signed({2'b00, stripe_reg}) + (SW+2)'(1);
                    end
                    if (cand < 0)
                        cand = '0;
                    if (cand > $signed({2'b00, LAST}))
                        cand = $signed({2'b00, LAST});
                    stripe_next = cand[SW-1:0];
                    ve_c = '0;
                end
                else if ((ndn_reg && v_reg > 0) || (!ndn_reg && v_reg < 0))
                    ve_c = '0;
            end
            else
                edge_next = 1'b0;
            ve = ve_c[31:0];
            vn = ndn_next ? 32'(-cr34) : 32'(cr34);
            pn = n_reg;
            pe = e_reg;
            if (n_reg > nmax_reg)
                pn = sat32(n34 - $signed(FOV_EIGHTH_Q));
            else if (n_reg < nmin_reg)
                pn = sat32(n34 + $signed(FOV_EIGHTH_Q));
            if (e_reg > emax_reg)
                pe = sat32(e34 - $signed(FOV_EIGHTH_Q));
            else if (e_reg < emin_reg)
                pe = sat32(e34 + $signed(FOV_EIGHTH_Q));
        end
    end

    // next state
    logic fin_go;
    assign fin_go = (state_reg == S_FIN) && (!ovalid_reg || guide.ready);

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        if (ovalid_reg && guide.ready)
            ovalid_next = 1'b0;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_DIV;
            S_DIV:  if (div_stat.done) state_next = S_WALK;
            S_WALK: if (idx_reg == LAST) state_next = S_MUL;
            S_MUL:  state_next = S_FIN;
            S_FIN:
            begin
                if (fin_go)
                begin
                    state_next  = S_IDLE;
                    ovalid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            phase_reg  <= 1'b0;
            edge_reg   <= 1'b0;
            esn_reg    <= 1'b0;
            ndn_reg    <= 1'b0;
            stripe_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            if (fin_go)
            begin
                phase_reg  <= phase_next;
                edge_reg   <= edge_next;
                esn_reg    <= esn_next;
                ndn_reg    <= ndn_next;
                stripe_reg <= stripe_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hd_reg <= sense.heading;
            n_reg  <= sense.north_pos;
            e_reg  <= sense.east_pos;
            d_reg  <= sense.down_pos;
            v_reg  <= sense.north_vel;
        end
        if (state_reg == S_DIV && div_stat.done)
        begin
            acc_reg <= 40'(emin_reg) + 40'(FOV_QUARTER_Q);
            idx_reg <= '0;
        end
        if (state_reg == S_WALK)
        begin
            acc_reg <= acc_reg + 40'(delta);
            idx_reg <= idx_reg + 1'b1;
            if (idx_reg == '0 || dist_w < bd_reg)
            begin
                bd_reg   <= dist_w;
                best_reg <= idx_reg;
            end
            if (idx_reg == stripe_reg)
                target_reg <= pos_w;
        end
        if (state_reg == S_MUL)
            prod_reg <= (33'(target_reg) - 33'(e_reg)) * GAIN_C;
        if (fin_go)
        begin
            o_hd_reg   <= hd_reg;
            o_pn_reg   <= pn;
            o_pe_reg   <= pe;
            o_pd_reg   <= dcmd[31:0];
            o_vn_reg   <= vn;
            o_ve_reg   <= ve;
            o_srch_reg <= phase_reg;
        end
    end

    assign sense.ready         = (state_reg == S_IDLE);
    assign guide.valid         = ovalid_reg;
    assign guide.heading_cmd   = o_hd_reg;
    assign guide.pos_north_cmd = o_pn_reg;
    assign guide.pos_east_cmd  = o_pe_reg;
    assign guide.pos_down_cmd  = o_pd_reg;
    assign guide.vel_north_cmd = o_vn_reg;
    assign guide.vel_east_cmd  = o_ve_reg;
    assign guide.searching     = o_srch_reg;

    // sequencer checks
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == S_DIV)
        else $error("divider running outside divide state");
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_DIV && div_stat.busy)
        else $error("accepted request did not start divider");
    a_phase_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |=> phase_reg)
        else $error("search phase left");
    a_stripe_range: assert property (@(posedge clk) disable iff (!rst_n)
        stripe_reg <= LAST)
        else $error("stripe number out of range");

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// testbench for the lawnmower search guidance block: directed and random sensor requests
// checked against an in-bench predictor; depends on lsg_pkg, lsg_if and the rtl top level
`timescale 1ns / 1ps
module tb;
    import lsg_pkg::*;

    localparam int NSTR = NUM_STRIPES_DEF;
    localparam int GAIN = GAIN_Q8_DEF;
    localparam longint FOV_HALF = 59927;
    localparam longint FOV_QTR  = 29963;
    localparam longint FOV_8TH  = 14982;
    localparam longint HTOL     = 1311;

    typedef struct packed {
        logic signed [31:0] heading;
        logic signed [31:0] north_pos;
        logic signed [31:0] east_pos;
        logic signed [31:0] down_pos;
        logic signed [31:0] north_vel;
    } sense_t;

    typedef struct packed {
        logic signed [31:0] heading_cmd;
        logic signed [31:0] pos_north_cmd;
        logic signed [31:0] pos_east_cmd;
        logic signed [31:0] pos_down_cmd;
        logic signed [31:0] vel_north_cmd;
        logic signed [31:0] vel_east_cmd;
        logic               searching;
    } guide_t;

    logic clk;
    logic rst_n;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_index;
    logic [DATA_W-1:0] wr_data;

    lsg_sense_if sense ();
    lsg_guide_if guide ();

    lawnmower_search_guidance dut (
        .clk(clk), .rst_n(rst_n), .sense(sense.sink), .guide(guide.source),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    // predictor copy of registers and state
    longint r_nmin, r_nmax, r_emin, r_emax, r_cruise, r_height, r_tn, r_te;
    bit     p_search, p_edge, p_estep_neg, p_ndir_neg;
    int     p_stripe;

    guide_t cmd_q[$];
    int     errors;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_off;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // overall limit
    initial
    begin
        #40ms;
        $display("FAIL lawnmower_search_guidance");
        $finish;
    end

    function automatic longint sat(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint stripe_east(input int i);
        longint span;
        span = r_emax - r_emin - FOV_HALF;
        return sat(r_emin + FOV_QTR + longint'(i) * (span / (NSTR - 1)));
    endfunction

    function automatic int closest_stripe(input longint e);
        int best;
        longint bd;
        longint dd;
        best = 0;
        bd = mag(stripe_east(0) - e);
        for (int i = 1; i < NSTR; i++)
        begin
            dd = mag(stripe_east(i) - e);
            if (dd < bd)
            begin
                bd = dd;
                best = i;
            end
        end
        return best;
    endfunction

    function automatic longint floor256(input longint v);
        if (v >= 0)
            return v / 256;
        return -((-v + 255) / 256);
    endfunction

    // work out the guidance command for one sensor request
    function automatic guide_t guidance_cmd(input sense_t s);
        guide_t g;
        longint n, e, dn, vnow, dcmd, pn, pe, vn, ve, tgt;
        int nxt;
        n = s.north_pos;
        e = s.east_pos;
        dn = s.down_pos;
        vnow = s.north_vel;
        dcmd = -r_height;
        g.searching = p_search;
        if (!p_search)
        begin
            pn = r_tn;
            pe = r_te;
            vn = 0;
            ve = 0;
            if (mag(dcmd - dn) < HTOL)
            begin
                p_search = 1'b1;
                p_estep_neg = mag(r_emax - e) < mag(r_emin - e);
                p_ndir_neg = mag(r_nmax - n) < mag(r_nmin - n);
                p_stripe = closest_stripe(e);
            end
        end
        else
        begin
            if (p_stripe >= NSTR)
                p_stripe = NSTR - 1;
            tgt = stripe_east(p_stripe);
            if (n > r_nmax - FOV_QTR || n < r_nmin + FOV_QTR)
            begin
                if (!p_edge)
                begin
                    p_edge = 1'b1;
                    p_ndir_neg = !p_ndir_neg;
                    nxt = p_stripe + (p_estep_neg ? -1 : 1);
                    if (nxt >= NSTR || nxt < 0)
                    begin
                        p_estep_neg = !p_estep_neg;
                        nxt = p_stripe + (p_estep_neg ? -1 : 1);
                    end
                    if (nxt < 0)
                        nxt = 0;
                    if (nxt >= NSTR)
                        nxt = NSTR - 1;
                    p_stripe = nxt;
                    ve = 0;
                end
                else if ((p_ndir_neg && vnow > 0) || (!p_ndir_neg && vnow < 0))
                    ve = 0;
                else
                    ve = floor256(longint'(GAIN) * (tgt - e));
            end
            else
            begin
                ve = floor256(longint'(GAIN) * (tgt - e));
                p_edge = 1'b0;
            end
            if (ve > r_cruise)
                ve = r_cruise;
            if (ve < -r_cruise)
                ve = -r_cruise;
            vn = p_ndir_neg ? -r_cruise : r_cruise;
            pn = n;
            pe = e;
            if (n > r_nmax)
                pn = sat(n - FOV_8TH);
            else if (n < r_nmin)
                pn = sat(n + FOV_8TH);
            if (e > r_emax)
                pe = sat(e - FOV_8TH);
            else if (e < r_emin)
                pe = sat(e + FOV_8TH);
        end
        g.heading_cmd = s.heading;
        g.pos_north_cmd = pn[31:0];
        g.pos_east_cmd = pe[31:0];
        g.pos_down_cmd = dcmd[31:0];
        g.vel_north_cmd = vn[31:0];
        g.vel_east_cmd = ve[31:0];
        return g;
    endfunction

    // register write, block idle
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_NORTH_MIN: r_nmin = longint'($signed(val));
            REG_NORTH_MAX: r_nmax = longint'($signed(val));
            REG_EAST_MIN:  r_emin = longint'($signed(val));
            REG_EAST_MAX:  r_emax = longint'($signed(val));
            REG_CRUISE:    r_cruise = longint'(val[30:0]);
            REG_HEIGHT:    r_height = longint'(val[30:0]);
            REG_TGT_NORTH: r_tn = longint'($signed(val));
            default:       r_te = longint'($signed(val));
        endcase
    endtask

    // valid stays up after the accept until the next request or a drain takes it down
    task automatic send_request(input sense_t s);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            sense.valid <= 1'b0;
            @(posedge clk);
        end
        sense.valid <= 1'b1;
        sense.heading <= s.heading;
        sense.north_pos <= s.north_pos;
        sense.east_pos <= s.east_pos;
        sense.down_pos <= s.down_pos;
        sense.north_vel <= s.north_vel;
        @(posedge clk);
        while (!sense.ready)
            @(posedge clk);
        cmd_q.push_back(guidance_cmd(s));
    endtask

    // wait for all commands, then the block latency
    task automatic drain();
        sense.valid <= 1'b0;
        while (cmd_q.size() != 0)
            @(posedge clk);
        repeat (NSTR + 50) @(posedge clk);
    endtask

    // drain, then a new search area, cruise, height and random target via register writes
    task automatic set_area(input int nmin, input int nmax, input int emin, input int emax,
                            input int cruise, input int height);
        drain();
        write_reg(REG_NORTH_MIN, nmin);
        write_reg(REG_NORTH_MAX, nmax);
        write_reg(REG_EAST_MIN, emin);
        write_reg(REG_EAST_MAX, emax);
        write_reg(REG_CRUISE, cruise);
        write_reg(REG_HEIGHT, height);
        write_reg(REG_TGT_NORTH, $urandom);
        write_reg(REG_TGT_EAST, $urandom);
    endtask

    function automatic sense_t near_item(input int span_n, input int span_e);
        sense_t s;
        s.heading = $urandom;
        s.north_pos = int'(r_nmin) - 40000 + int'($urandom_range(span_n));
        s.east_pos = int'(r_emin) - 40000 + int'($urandom_range(span_e));
        s.down_pos = ($urandom_range(3) == 0) ? $urandom
                     : int'(-r_height) - 1400 + int'($urandom_range(2800));
        s.north_vel = $urandom_range(1) ? int'($urandom_range(200000))
                      : -int'($urandom_range(200000));
        return s;
    endfunction

    function automatic sense_t raw_item();
        sense_t s;
        s = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return s;
    endfunction

    // extremes and takeoff exit at the boundary of the tolerance
    task automatic test_directed();
        sense_t s;
        set_area(-655360, 655360, -655360, 655360, 65536, 131072);
        s = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0};
        send_request(s);
        s = '{0, 0, 0, -131072 + 1311, 0};
        send_request(s);
        s = '{0, 0, 0, -131072 + 1310, 0};
        send_request(s);
        s = '{32'sh8000_0000, 655000, 700000, 0, 100};
        send_request(s);
        s = '{1, 655000, 700000, 0, -100};
        send_request(s);
        s = '{2, -655000, -700000, 0, 100};
        send_request(s);
        s = '{3, -655000, -700000, 0, -5};
        send_request(s);
        s = '{4, 0, 0, 0, 0};
        send_request(s);
        s = '{5, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF};
        send_request(s);
        s = '{6, 32'sh8000_0000, 32'sh8000_0000, 0, 32'sh8000_0000};
        send_request(s);
        // extreme bounds and speed, zero height
        set_area(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                 32'h7FFF_FFFF, 0);
        for (int i = 0; i < 10; i++)
            send_request(raw_item());
        s = '{0, 0, 0, 0, 0};
        send_request(s);
        for (int i = 0; i < 4; i++)
            send_request(raw_item());
    endtask

    // random areas with mostly well formed flight
    task automatic test_random(input int count);
        int w;
        int h;
        for (int k = 0; k < count / 40; k++)
        begin
            w = $urandom_range(20000, 3000000);
            h = $urandom_range(20000, 3000000);
            set_area(-int'($urandom_range(2000000)), 0, -int'($urandom_range(2000000)), 0,
                     $urandom_range(1) ? $urandom_range(200000) : $urandom, $urandom_range(300000));
            write_reg(REG_NORTH_MAX, int'(r_nmin) + h);
            write_reg(REG_EAST_MAX, int'(r_emin) + w);
            for (int i = 0; i < 40; i++)
                send_request(($urandom_range(9) == 0) ? raw_item() : near_item(h + 80000, w + 80000));
        end
    endtask

    // long hold-off on the command side so the block backs up
    task automatic test_backpressure();
        drain();
        hold_off = 300;
        for (int i = 0; i < 12; i++)
            send_request(near_item(300000, 300000));
    endtask

    // command side ready and checker
    always @(posedge clk)
    begin
        if (!rst_n)
            guide.ready <= 1'b0;
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            guide.ready <= 1'b0;
        end
        else
            guide.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        guide_t got;
        guide_t want;
        if (rst_n && guide.valid && guide.ready)
        begin
            got = '{guide.heading_cmd, guide.pos_north_cmd, guide.pos_east_cmd,
                    guide.pos_down_cmd, guide.vel_north_cmd, guide.vel_east_cmd,
                    guide.searching};
            if (cmd_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected command %p", got);
            end
            else
            begin
                want = cmd_q.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    // sequence of tests
    initial
    begin
        errors = 0;
        hold_off = 0;
        send_idle_pct = 16;
        recv_idle_pct = 65;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        sense.valid = 1'b0;
        sense.heading = '0;
        sense.north_pos = '0;
        sense.east_pos = '0;
        sense.down_pos = '0;
        sense.north_vel = '0;
        r_nmin = 0; r_nmax = 0; r_emin = 0; r_emax = 0;
        r_cruise = 0; r_height = 0; r_tn = 0; r_te = 0;
        p_search = 0; p_edge = 0; p_estep_neg = 0; p_ndir_neg = 0; p_stripe = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset state, registers still zero
        send_request('{7, 0, 0, 0, 0});
        send_request('{8, 100, -100, 0, 0});
        test_directed();
        test_random(120);
        test_backpressure();
        send_idle_pct = 65;
        recv_idle_pct = 16;
        test_random(120);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(160);
        drain();
        if (errors == 0 && cmd_q.size() == 0)
            $display("PASS lawnmower_search_guidance");
        else
            $display("FAIL lawnmower_search_guidance");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/lsg_pkg.sv
rtl/lsg_if.sv
rtl/lsg_cdiv.sv
rtl/lawnmower_search_guidance.sv
sim/tb.sv
